// ===== rtl/skf_pkg.sv =====
package skf_pkg;

    // Fixed widths of the configuration registers and the filter state.
    localparam int REG_W = 24;
    localparam int EST_W = 32;
    localparam int VAR_W = 32;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register reset values (Q and R, fixed point).
    localparam logic [REG_W-1:0] Q_RESET = 24'd655;
    localparam logic [REG_W-1:0] R_RESET = 24'd299500;

    // Register indexes, taken from address bit 2.
    typedef enum logic {
        REG_PROCESS_NOISE     = 1'b0,
        REG_MEASUREMENT_NOISE = 1'b1
    } reg_idx_t;

    // Handshake between the control sequencer and the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/skf_div.sv =====
module skf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [skf_pkg::VAR_W-1:0]     num,
    input  logic [skf_pkg::VAR_W:0]       den,
    output skf_pkg::div_status_t          status,
    output logic [FRAC_BITS:0]            quot
);
    import skf_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 2);
    localparam int RW = VAR_W + 2;

    logic [RW-1:0]      rem_reg;
    logic [VAR_W:0]     den_reg;
    logic [FRAC_BITS:0] q_reg;
    logic [CW-1:0]      cnt_reg;
    logic               zero_reg;
    logic               done_reg;

    logic [RW-1:0] den_ext;
    logic          ge;
    logic [RW-1:0] diff;
    logic [RW-1:0] rem_next;

    // One quotient bit per cycle: compare, subtract, shift.
    assign den_ext  = {1'b0, den_reg};
    assign ge       = (rem_reg >= den_ext);
    assign diff     = ge ? (rem_reg - den_ext) : rem_reg;
    assign rem_next = {diff[RW-2:0], 1'b0};

    // Control: step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(FRAC_BITS + 1);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, divisor and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {2'b00, num};
            den_reg  <= den;
            zero_reg <= (den == '0);
            q_reg    <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[FRAC_BITS-1:0], ge};
        end
    end

    // A zero divisor yields a zero gain.
    assign quot        = zero_reg ? '0 : q_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (cnt_reg == '0))
        else $error("divider started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cnt_reg == CW'(1)))
        else $error("divider done without a final step");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && !zero_reg) |-> (rem_reg < {den_ext[RW-2:0], 1'b0}))
        else $error("divider remainder out of range");

endmodule

// ===== rtl/scalar_kalman_filter.sv =====
// Each accepted sample goes through the bit-serial divider, which forms the gain, then the
// two shift-add multipliers, one gain bit per cycle, then the finish step, which waits for
// the output register to be free. A new sample is taken as soon as the sequencer is idle,
// even while an estimate waits.
// Reset (asynchronous, rst_n low): filter estimate 0, variance 1.0, Q = 655, R = 299500.
module scalar_kalman_filter #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [skf_pkg::EST_W-1:0] estimate,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [skf_pkg::APB_AW-1:0]      paddr,
    input  logic [skf_pkg::APB_DW-1:0]      pwdata,
    output logic [skf_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import skf_pkg::*;

    localparam int ZW     = SAMPLE_BITS + FRAC_BITS;
    localparam int DIFF_W = ((ZW > EST_W) ? ZW : EST_W) + 1;
    localparam int A1W    = DIFF_W + 1;
    localparam int XW     = A1W + 1;
    localparam int A2W    = VAR_W + 1;
    localparam int PW     = VAR_W + 2;
    localparam int MCW    = $clog2(FRAC_BITS + 2);
    localparam logic [FRAC_BITS:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAR_W-1:0]   VAR_RESET = VAR_W'(ONE_FIX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t state_reg;

    logic [REG_W-1:0]         q_reg;
    logic [REG_W-1:0]         r_reg;
    logic signed [EST_W-1:0]  x_reg;
    logic [VAR_W-1:0]         p_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [EST_W-1:0]  estimate_reg;
    logic [MCW-1:0]           mul_cnt_reg;

    logic signed [DIFF_W-1:0] diff_reg;
    logic [FRAC_BITS:0]       g_sh_reg;
    logic [FRAC_BITS:0]       om_sh_reg;
    logic signed [A1W-1:0]    acc1_reg;
    logic [A2W-1:0]           acc2_reg;

    logic                     in_accept;
    logic                     cfg_write;
    div_status_t              div_stat;
    logic [FRAC_BITS:0]       div_q;
    logic [VAR_W:0]           den;
    logic signed [DIFF_W-1:0] z_ext;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [A1W-1:0]    add1;
    logic signed [A1W-1:0]    sum1;
    logic [A2W-1:0]           add2;
    logic [A2W-1:0]           sum2;
    logic                     last_bit;
    logic signed [A1W-1:0]    acc1_next;
    logic [A2W-1:0]           acc2_next;
    logic signed [XW-1:0]     x_full;
    logic signed [EST_W-1:0]  x_sat;
    logic [PW-1:0]            p_full;
    logic [VAR_W-1:0]         p_sat;
    logic                     out_free;

    // Configuration port: zero-wait writes, combinational reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_PROCESS_NOISE:     prdata = APB_DW'(q_reg);
            REG_MEASUREMENT_NOISE: prdata = APB_DW'(r_reg);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            r_reg <= R_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_PROCESS_NOISE:     q_reg <= pwdata[REG_W-1:0];
                REG_MEASUREMENT_NOISE: r_reg <= pwdata[REG_W-1:0];
                default:               q_reg <= q_reg;
            endcase
        end
    end

    // Input handshake and innovation: sample scaled to fixed point minus the estimate.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign z_ext     = DIFF_W'({{(DIFF_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample})
                       <<< FRAC_BITS;
    assign diff_next = z_ext - DIFF_W'(x_reg);
    assign den       = {1'b0, p_reg} + (VAR_W + 1)'(r_reg);

    // Gain K = P / (P + R), one quotient bit per cycle.
    skf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept),
        .num    (p_reg),
        .den    (den),
        .status (div_stat),
        .quot   (div_q)
    );

    // Two shift-add multipliers, LSB first; the dropped low bits give the floor shift.
    assign last_bit  = (mul_cnt_reg == MCW'(1));
    assign add1      = g_sh_reg[0] ? A1W'(diff_reg) : '0;
    assign sum1      = acc1_reg + add1;
    assign acc1_next = last_bit ? sum1 : (sum1 >>> 1);
    assign add2      = om_sh_reg[0] ? A2W'(p_reg) : '0;
    assign sum2      = acc2_reg + add2;
    assign acc2_next = last_bit ? sum2 : (sum2 >> 1);

    // New estimate and variance with saturation.
    assign x_full = XW'(x_reg) + XW'(acc1_reg);
    always_comb
    begin
        if (x_full[XW-1:EST_W-1] == '0 || x_full[XW-1:EST_W-1] == '1)
        begin
            x_sat = x_full[EST_W-1:0];
        end
        else
        begin
            x_sat = {x_full[XW-1], {(EST_W-1){~x_full[XW-1]}}};
        end
    end

    assign p_full = PW'(acc2_reg) + PW'(q_reg);
    assign p_sat  = (p_full[PW-1:VAR_W] != '0) ? '1 : p_full[VAR_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    // The output register fills from the finish step and empties when its item is taken.
    always_comb
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Sequencer, filter state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_reg         <= '0;
            p_reg         <= VAR_RESET;
            out_valid_reg <= 1'b0;
            mul_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        mul_cnt_reg <= MCW'(FRAC_BITS + 1);
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    mul_cnt_reg <= mul_cnt_reg - MCW'(1);
                    if (last_bit)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        x_reg     <= x_sat;
                        p_reg     <= p_sat;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == ST_DIV && div_stat.done)
        begin
            g_sh_reg  <= div_q;
            om_sh_reg <= ONE_FIX - div_q;
            acc1_reg  <= '0;
            acc2_reg  <= '0;
        end
        else if (state_reg == ST_MUL)
        begin
            g_sh_reg  <= g_sh_reg >> 1;
            om_sh_reg <= om_sh_reg >> 1;
            acc1_reg  <= acc1_next;
            acc2_reg  <= acc2_next;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            estimate_reg <= x_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_q <= ONE_FIX))
        else $error("gain above one");

    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (!div_stat.busy && mul_cnt_reg != '0))
        else $error("multiplier running with divider busy or no bits left");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("estimate presented outside the finish step");

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside the divide phase");

endmodule
